>>> rtl/tlt_pkg.sv
`timescale 1ns / 1ps

package tlt_pkg;

  localparam int CoordW    = 24;
  localparam int WidthW    = 16;
  localparam int ColorW    = 32;
  localparam int VnumW     = 3;
  localparam int NormSteps = 5;
  localparam int SqrtSteps = 31;
  localparam int DivSteps  = 16;
  localparam int SqW       = 62;
  localparam int AxW       = 31;
  localparam int NumW      = 48;
  localparam int DenW      = 32;
  localparam int OffW      = 18;

  localparam int StNorm = 3;
  localparam int StSqrt = StNorm + NormSteps;
  localparam int StMul  = StSqrt + SqrtSteps;
  localparam int StAdd  = StMul + 1;
  localparam int StDiv  = StAdd + 1;
  localparam int StOff  = StDiv + DivSteps;
  localparam int NStage = StOff + 1;

  localparam logic [VnumW-1:0] LastVertex = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] p1x;
    logic signed [CoordW-1:0] p1y;
    logic signed [CoordW-1:0] p2x;
    logic signed [CoordW-1:0] p2y;
    logic [WidthW-1:0]        w;
    logic [ColorW-1:0]        color;
    logic                     horiz;
    logic                     neg;
    logic                     dxz;
  } side_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [CoordW+1:0] v);
    logic signed [CoordW+1:0] hi;
    logic signed [CoordW+1:0] lo;
    hi = (CoordW+2)'(2 ** (CoordW - 1) - 1);
    lo = -(CoordW+2)'(2 ** (CoordW - 1));
    if (v > hi) return hi[CoordW-1:0];
    if (v < lo) return lo[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

endpackage

>>> rtl/thick_line_to_triangles_top.sv
`timescale 1ns / 1ps

// Widens a segment into a rectangle and sends it as six vertices (two triangles). Each
// request runs through a 58-stage pipeline (difference, squares, normalization, a 31-stage
// square root, multiply, a 16-stage divider, offsets) and then a vertex sequencer that emits
// one vertex per cycle while out_ready is high; the single output port, which emits six
// vertices per request, limits how often new requests are taken, and the pipeline stalls
// while its last stage holds a request and the sequencer is busy.
module thick_line_to_triangles_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tlt_pkg::CoordW-1:0]    start_x,
  input  logic signed [tlt_pkg::CoordW-1:0]    start_y,
  input  logic signed [tlt_pkg::CoordW-1:0]    end_x,
  input  logic signed [tlt_pkg::CoordW-1:0]    end_y,
  input  logic        [tlt_pkg::WidthW-1:0]    line_width,
  input  logic        [tlt_pkg::ColorW-1:0]    line_color,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tlt_pkg::CoordW-1:0]    vertex_x,
  output logic signed [tlt_pkg::CoordW-1:0]    vertex_y,
  output logic        [tlt_pkg::VnumW-1:0]     vertex_number,
  output logic        [tlt_pkg::ColorW-1:0]    vertex_color,
  output logic                                 last_vertex
);

  localparam int CW = tlt_pkg::CoordW;
  localparam int NS = tlt_pkg::NStage;
  localparam int SW = tlt_pkg::SqW;
  localparam int AW = tlt_pkg::AxW;
  localparam int NW = tlt_pkg::NumW;
  localparam int DW = tlt_pkg::DenW;
  localparam int OW = tlt_pkg::OffW;
  localparam int QW = tlt_pkg::DivSteps;

  logic                 vld [0:NS-1];
  tlt_pkg::side_t       side [0:NS-1];
  logic                 en;
  logic                 take;

  // Entry stage.
  logic signed [CW:0]   dx;
  logic signed [CW:0]   dy;
  logic [CW:0]          adx_full;
  logic [CW:0]          ady_full;
  tlt_pkg::side_t       side_in;
  logic                 swap;
  logic [CW-1:0]        adx;
  logic [CW-1:0]        ady;

  always_comb begin
    dx = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    dy = {start_y[CW-1], start_y} - {end_y[CW-1], end_y};
    adx_full = dx[CW] ? (CW+1)'(-dx) : dx;
    ady_full = dy[CW] ? (CW+1)'(-dy) : dy;
    side_in.horiz = (dy == '0);
    swap = side_in.horiz ? (end_x < start_x) : (start_y < end_y);
    side_in.p1x = swap ? end_x : start_x;
    side_in.p1y = swap ? end_y : start_y;
    side_in.p2x = swap ? start_x : end_x;
    side_in.p2y = swap ? start_y : end_y;
    side_in.w = line_width;
    side_in.color = line_color;
    side_in.neg = dx[CW] ^ dy[CW];
    side_in.dxz = (dx == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < NS; i++) side[i] <= side[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx <= adx_full[CW-1:0];
      ady <= ady_full[CW-1:0];
    end
  end

  // Squares and sum.
  logic [2*CW-1:0] sqx;
  logic [2*CW-1:0] sqy;
  logic [CW-1:0]   adx1;
  logic [CW-1:0]   ady1;
  logic [SW-1:0]   ssum;
  logic [AW-1:0]   ax2;
  logic [AW-1:0]   ay2;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= adx * adx;
      sqy <= ady * ady;
      adx1 <= adx;
      ady1 <= ady;
      ssum <= SW'(sqx) + SW'(sqy);
      ax2 <= AW'(adx1);
      ay2 <= AW'(ady1);
    end
  end

  // Normalization: shift the sum left by pairs of bits until its top pair is nonzero.
  logic [SW-1:0] ns [0:tlt_pkg::NormSteps];
  logic [AW-1:0] nax [0:tlt_pkg::NormSteps];
  logic [AW-1:0] nay [0:tlt_pkg::NormSteps];

  assign ns[0] = ssum;
  assign nax[0] = ax2;
  assign nay[0] = ay2;

  for (genvar j = 0; j < tlt_pkg::NormSteps; j++) begin : g_norm
    localparam int Step = 2 ** (tlt_pkg::NormSteps - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        if (ns[j][SW-1 -: 2*Step] == '0) begin
          ns[j+1] <= ns[j] << (2 * Step);
          nax[j+1] <= nax[j] << Step;
          nay[j+1] <= nay[j] << Step;
        end else begin
          ns[j+1] <= ns[j];
          nax[j+1] <= nax[j];
          nay[j+1] <= nay[j];
        end
      end
    end
  end

  // Square root, one result bit per stage.
  logic [SW-1:0] rn  [0:tlt_pkg::SqrtSteps];
  logic [SW-1:0] rr  [0:tlt_pkg::SqrtSteps];
  logic [AW-1:0] rax [0:tlt_pkg::SqrtSteps];
  logic [AW-1:0] ray [0:tlt_pkg::SqrtSteps];

  assign rn[0] = ns[tlt_pkg::NormSteps];
  assign rr[0] = '0;
  assign rax[0] = nax[tlt_pkg::NormSteps];
  assign ray[0] = nay[tlt_pkg::NormSteps];

  for (genvar t = 0; t < tlt_pkg::SqrtSteps; t++) begin : g_sqrt
    localparam logic [SW:0] Bit = (SW+1)'(1) << (SW - 2 - 2 * t);
    logic [SW:0] trial;
    assign trial = {1'b0, rr[t]} + Bit;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rn[t]} >= trial) begin
          rn[t+1] <= rn[t] - trial[SW-1:0];
          rr[t+1] <= (rr[t] >> 1) + Bit[SW-1:0];
        end else begin
          rn[t+1] <= rn[t];
          rr[t+1] <= rr[t] >> 1;
        end
        rax[t+1] <= rax[t];
        ray[t+1] <= ray[t];
      end
    end
  end

  // Numerators and denominator.
  logic [AW-1:0]             len_m;
  logic [NW-2:0]             prx;
  logic [NW-2:0]             pry;
  logic [NW-1:0]             dnx [0:QW];
  logic [NW-1:0]             dny [0:QW];
  logic [DW-1:0]             den [0:QW];
  logic [QW-1:0]             qx  [0:QW];
  logic [QW-1:0]             qy  [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      prx <= side[tlt_pkg::StMul-1].w * ray[tlt_pkg::SqrtSteps];
      pry <= side[tlt_pkg::StMul-1].w * rax[tlt_pkg::SqrtSteps];
      len_m <= rr[tlt_pkg::SqrtSteps][AW-1:0];
      dnx[0] <= NW'(prx) + NW'(len_m);
      dny[0] <= NW'(pry) + NW'(len_m);
      den[0] <= {len_m, 1'b0};
    end
  end

  assign qx[0] = '0;
  assign qy[0] = '0;

  // Restoring divider, one quotient bit per stage.
  for (genvar d = 0; d < QW; d++) begin : g_div
    localparam int Sh = QW - 1 - d;
    logic [NW-1:0] dsh;
    assign dsh = NW'(den[d]) << Sh;
    always_ff @(posedge clk) begin
      if (en) begin
        den[d+1] <= den[d];
        if (dnx[d] >= dsh) begin
          dnx[d+1] <= dnx[d] - dsh;
          qx[d+1] <= qx[d] | (QW'(1) << Sh);
        end else begin
          dnx[d+1] <= dnx[d];
          qx[d+1] <= qx[d];
        end
        if (dny[d] >= dsh) begin
          dny[d+1] <= dny[d] - dsh;
          qy[d+1] <= qy[d] | (QW'(1) << Sh);
        end else begin
          dny[d+1] <= dny[d];
          qy[d+1] <= qy[d];
        end
      end
    end
  end

  // Offsets.
  logic signed [OW-1:0] ox;
  logic signed [OW-1:0] oy;
  tlt_pkg::side_t       sd_o;

  assign sd_o = side[tlt_pkg::StOff-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd_o.horiz) begin
        ox <= '0;
        oy <= OW'((OW'(sd_o.w) + OW'(1)) >> 1);
      end else begin
        ox <= OW'(qx[QW]);
        if (sd_o.dxz) oy <= '0;
        else if (sd_o.neg) oy <= -OW'(qy[QW]);
        else oy <= OW'(qy[QW]);
      end
    end
  end

  // Vertex sequencer and output register.
  tlt_pkg::side_t               hold;
  logic signed [OW-1:0]         hox;
  logic signed [OW-1:0]         hoy;
  logic                         hv;
  logic [tlt_pkg::VnumW-1:0]    cnt;
  logic                         load;
  logic                         use_p2;
  logic                         plus;
  logic signed [CW+1:0]         bx;
  logic signed [CW+1:0]         by;
  logic signed [CW+1:0]         vx;
  logic signed [CW+1:0]         vy;

  assign load = hv && (!out_valid || out_ready);
  assign take = vld[NS-1] && (!hv || (load && cnt == tlt_pkg::LastVertex));
  assign en = !vld[NS-1] || take;
  assign in_ready = en;

  always_comb begin
    use_p2 = cnt[0];
    plus = 1'b0;
    case (cnt)
      3'd2, 3'd3, 3'd4: plus = 1'b1;
      default: plus = 1'b0;
    endcase
    bx = use_p2 ? (CW+2)'(hold.p2x) : (CW+2)'(hold.p1x);
    by = use_p2 ? (CW+2)'(hold.p2y) : (CW+2)'(hold.p1y);
    vx = plus ? bx + (CW+2)'(hox) : bx - (CW+2)'(hox);
    vy = plus ? by + (CW+2)'(hoy) : by - (CW+2)'(hoy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        hv <= 1'b1;
        cnt <= '0;
      end else if (load) begin
        if (cnt == tlt_pkg::LastVertex) begin
          hv <= 1'b0;
          cnt <= '0;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold <= side[NS-1];
      hox <= ox;
      hoy <= oy;
    end
    if (load) begin
      vertex_x <= tlt_pkg::sat_coord(vx);
      vertex_y <= tlt_pkg::sat_coord(vy);
      vertex_number <= cnt;
      vertex_color <= hold.color;
      last_vertex <= (cnt == tlt_pkg::LastVertex);
    end
  end

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_vertex == (vertex_number == tlt_pkg::LastVertex)))
    else $error("last_vertex does not match vertex_number");

  a_seq_next: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_vertex) |=>
      (out_valid && vertex_number == $past(vertex_number) + 3'd1))
    else $error("vertex sequence broken");

  a_stall_pipe: assert property (@(posedge clk) disable iff (rst)
    (vld[NS-1] && hv && !(load && cnt == tlt_pkg::LastVertex)) |-> !in_ready)
    else $error("pipeline advanced while sequencer busy");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    hv |-> (cnt <= tlt_pkg::LastVertex))
    else $error("vertex counter out of range");

endmodule
